>>> design/average_srgb_tonemap_pixel_top_macros.svh
// assertion macros shared by the sRGB tone-map pixel design
`ifndef AVERAGE_SRGB_TONEMAP_PIXEL_TOP_MACROS_SVH
`define AVERAGE_SRGB_TONEMAP_PIXEL_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define ASTP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequence that must follow the antecedent (non-overlapping implication)
`define ASTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define ASTP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ASTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/astp_pkg.sv
// types, constants and the curve threshold table of the sRGB tone-map pixel block
`default_nettype none

package astp_pkg;

    localparam int CHANNELS = 3;
    localparam int SUM_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int PASS_W   = 16;

    // pipelined divider: quotient bits retired per stage
    localparam int QUO_W         = 32;
    localparam int DIV_STEP      = 4;
    localparam int DIV_STAGES    = QUO_W / DIV_STEP;
    localparam int SEARCH_STAGES = BYTE_W;
    localparam int MID_STAGES    = DIV_STAGES + 4 + SEARCH_STAGES;
    // input stage, middle stages, final select stage
    localparam int PIPE_DEPTH    = 1 + MID_STAGES + 1;

    localparam int NUM_CODES = 1 << BYTE_W;

    // 0.0031308 in Q0.32, rounded down
    localparam logic [QUO_W-1:0] LIN_LIMIT_Q32 = 32'd13446683;
    // 12.92 * 256 * 100
    localparam logic [18:0]      LIN_GAIN      = 19'd330752;
    // floor(y / 100) == (y * 5243) >> 19 for small y
    localparam logic [12:0]      RECIP_100     = 13'd5243;
    localparam int               EXP_U1_BASE   = -32;
    localparam logic [BYTE_W-1:0] SAT_CODE     = '1;

    // value = m * 2^e with m[31] set
    typedef struct packed {
        logic signed [7:0] e;
        logic [31:0]       m;
    } sfl_t;

    typedef sfl_t [NUM_CODES-1:0] c12_table_t;

    // product truncated to 32 mantissa bits
    function automatic sfl_t sfl_mul(sfl_t a, sfl_t b);
        logic [63:0] prod;
        sfl_t        r;
        prod = 64'(a.m) * 64'(b.m);
        if (prod[63]) begin
            r.m = prod[63:32];
            r.e = 8'(a.e + b.e + 8'sd32);
        end else begin
            r.m = prod[62:31];
            r.e = 8'(a.e + b.e + 8'sd31);
        end
        return r;
    endfunction

    function automatic logic sfl_le(sfl_t a, sfl_t b);
        return (a.e < b.e) || ((a.e == b.e) && (a.m <= b.m));
    endfunction

    // elaboration only: normalize a nonzero integer times 2^e0
    function automatic sfl_t sfl_from_int(logic [31:0] x, int e0);
        logic [31:0] m;
        int          e;
        sfl_t        r;
        m = x;
        e = e0;
        for (int i = 0; i < 32; i++) begin
            if (!m[31]) begin
                m = m << 1;
                e = e - 1;
            end
        end
        r.m = m;
        r.e = 8'(e);
        return r;
    endfunction

    // entry b: P_b^12 where P_b is the smallest Q0.24 root giving code b or above
    function automatic c12_table_t build_c12_table();
        c12_table_t        tab;
        longint unsigned   pb;
        sfl_t              c1;
        sfl_t              c2;
        sfl_t              c4;
        sfl_t              c8;
        tab = '0;
        for (int b = 1; b < NUM_CODES; b++) begin
            pb = ((64'(100 * b + 1408) << 24) + 64'd27007) / 64'd27008;
            c1 = sfl_from_int(32'(pb), -24);
            c2 = sfl_mul(c1, c1);
            c4 = sfl_mul(c2, c2);
            c8 = sfl_mul(c4, c4);
            tab[b] = sfl_mul(c8, c4);
        end
        return tab;
    endfunction

    localparam c12_table_t C12_TABLE = build_c12_table();

endpackage

`default_nettype wire

>>> design/astp_channel.sv
// one color channel of the tone-map pipeline: divide, encode, search the output code
`default_nettype none

module astp_channel (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [astp_pkg::PASS_W-1:0]       pass_n,
    input  logic signed [astp_pkg::SUM_W-1:0] sum_in,
    output logic [astp_pkg::BYTE_W-1:0]       byte_out
);
    import astp_pkg::*;

    typedef struct packed {
        logic [PASS_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
        logic [15:0]       low;
    } div_t;

    typedef struct packed {
        logic zero;
        logic sat;
        logic lin;
    } flag_t;

    function automatic div_t div_step(div_t d, logic [PASS_W-1:0] n);
        div_t          r;
        logic [PASS_W:0] t;
        r = d;
        for (int i = 0; i < DIV_STEP; i++) begin
            t     = {r.rem, r.low[15]};
            r.low = {r.low[14:0], 1'b0};
            if (t >= {1'b0, n}) begin
                r.rem = PASS_W'(t - {1'b0, n});
                r.quo = {r.quo[QUO_W-2:0], 1'b1};
            end else begin
                r.rem = t[PASS_W-1:0];
                r.quo = {r.quo[QUO_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic signed [SUM_W-1:0] raw_reg;

    div_t  div_reg  [DIV_STAGES];
    div_t  div_next [DIV_STAGES];
    flag_t flag_reg  [MID_STAGES];
    flag_t flag_next [MID_STAGES];

    sfl_t        u1_reg, u1_next;
    logic [10:0] lin_y_reg;
    logic [42:0] lin_prod;
    sfl_t        u2_reg, u1_d1_reg;
    logic [BYTE_W-1:0] lin_m2_reg;
    logic [23:0] recip_prod;
    sfl_t        u4_reg, u1_d2_reg;
    logic [BYTE_W-1:0] lin_m4_reg;
    sfl_t        u5_reg;
    logic [BYTE_W-1:0] lin_m5_reg;

    sfl_t              srch_u5_reg  [SEARCH_STAGES];
    logic [BYTE_W-1:0] srch_lin_reg [SEARCH_STAGES];
    logic [BYTE_W-1:0] code_reg     [SEARCH_STAGES];
    logic [BYTE_W-1:0] code_next    [SEARCH_STAGES];

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    logic [QUO_W-1:0] norm_m;
    logic [3:0]       norm_sh;
    div_t             div_first;
    flag_t            flag_first;

    // division, one group of quotient bits per stage
    always_comb begin
        div_first.rem = {1'b0, raw_reg[SUM_W-2:16]};
        div_first.quo = '0;
        div_first.low = raw_reg[15:0];
        flag_first.zero = raw_reg[SUM_W-1] || (raw_reg == '0);
        flag_first.sat  = ({1'b0, raw_reg[SUM_W-2:16]} >= pass_n);
        flag_first.lin  = 1'b0;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                div_next[k] = div_step(div_first, pass_n);
            end else begin
                div_next[k] = div_step(div_reg[k-1], pass_n);
            end
        end
        for (int k = 0; k < MID_STAGES; k++) begin
            if (k == 0) begin
                flag_next[k] = flag_first;
            end else begin
                flag_next[k] = flag_reg[k-1];
            end
        end
        flag_next[DIV_STAGES].lin = (div_reg[DIV_STAGES-1].quo <= LIN_LIMIT_Q32);
    end

    // normalize the quotient, at most eight leading zeros in the curve region
    always_comb begin
        norm_m  = div_reg[DIV_STAGES-1].quo;
        norm_sh = '0;
        if (norm_m[31:24] == 8'd0) begin
            norm_m  = norm_m << 8;
            norm_sh = norm_sh + 4'd8;
        end
        if (norm_m[31:28] == 4'd0) begin
            norm_m  = norm_m << 4;
            norm_sh = norm_sh + 4'd4;
        end
        if (norm_m[31:30] == 2'd0) begin
            norm_m  = norm_m << 2;
            norm_sh = norm_sh + 4'd2;
        end
        if (!norm_m[31]) begin
            norm_m  = norm_m << 1;
            norm_sh = norm_sh + 4'd1;
        end
        u1_next.m = norm_m;
        u1_next.e = 8'(EXP_U1_BASE - int'(norm_sh));
    end

    assign lin_prod   = 43'(div_reg[DIV_STAGES-1].quo[23:0]) * 43'(LIN_GAIN);
    assign recip_prod = 24'(lin_y_reg) * 24'(RECIP_100);

    // greedy search for the largest code whose threshold is not above u^5
    always_comb begin
        for (int s = 0; s < SEARCH_STAGES; s++) begin
            logic [BYTE_W-1:0] cand;
            sfl_t              u5v;
            if (s == 0) begin
                cand = BYTE_W'(1) << (SEARCH_STAGES - 1);
                u5v  = u5_reg;
            end else begin
                cand = code_reg[s-1] | (BYTE_W'(1) << (SEARCH_STAGES - 1 - s));
                u5v  = srch_u5_reg[s-1];
            end
            if (sfl_le(C12_TABLE[cand], u5v)) begin
                code_next[s] = cand;
            end else if (s == 0) begin
                code_next[s] = '0;
            end else begin
                code_next[s] = code_reg[s-1];
            end
        end
    end

    always_comb begin
        if (flag_reg[MID_STAGES-1].zero) begin
            byte_next = '0;
        end else if (flag_reg[MID_STAGES-1].sat) begin
            byte_next = SAT_CODE;
        end else if (flag_reg[MID_STAGES-1].lin) begin
            byte_next = srch_lin_reg[SEARCH_STAGES-1];
        end else begin
            byte_next = code_reg[SEARCH_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            raw_reg <= sum_in;
            for (int k = 0; k < DIV_STAGES; k++) begin
                div_reg[k] <= div_next[k];
            end
            for (int k = 0; k < MID_STAGES; k++) begin
                flag_reg[k] <= flag_next[k];
            end
            u1_reg     <= u1_next;
            lin_y_reg  <= lin_prod[42:32];
            u2_reg     <= sfl_mul(u1_reg, u1_reg);
            u1_d1_reg  <= u1_reg;
            lin_m2_reg <= BYTE_W'(recip_prod[23:19]);
            u4_reg     <= sfl_mul(u2_reg, u2_reg);
            u1_d2_reg  <= u1_d1_reg;
            lin_m4_reg <= lin_m2_reg;
            u5_reg     <= sfl_mul(u4_reg, u1_d2_reg);
            lin_m5_reg <= lin_m4_reg;
            for (int s = 0; s < SEARCH_STAGES; s++) begin
                code_reg[s] <= code_next[s];
                if (s == 0) begin
                    srch_u5_reg[s]  <= u5_reg;
                    srch_lin_reg[s] <= lin_m5_reg;
                end else begin
                    srch_u5_reg[s]  <= srch_u5_reg[s-1];
                    srch_lin_reg[s] <= srch_lin_reg[s-1];
                end
            end
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

>>> design/average_srgb_tonemap_pixel_top.sv
// top level of the sRGB tone-map pixel block: stream ports, pass count register, output buffer
`default_nettype none
`include "average_srgb_tonemap_pixel_top_macros.svh"

// Converts one pixel of accumulated linear radiance (three signed Q16.16 sums) into
// three 8-bit sRGB codes. Each sum is divided by the pass count (zero counts as one),
// sRGB encoded, scaled by 256, clamped to 0..255 and truncated; negative or zero sums
// give 0, sums at or above the pass count give 255. One pixel is accepted every clock
// while s_tready is high, and results leave in input order; the transfer edge loads
// the first of 22 pipeline stages, and the output register follows the last. The
// depth comes from the divider, which retires four quotient bits per stage over eight
// stages, three registered 32x32 mantissa products for u^5, and an eight-stage search
// of the code threshold table. A two-entry output buffer lets the pipeline keep taking
// pixels while a result waits; s_tready drops only once both entries are full. Write
// pass_count only while no pixel is in flight.
module average_srgb_tonemap_pixel_top (
    input  logic                    aclk,
    input  logic                    aresetn,
    // pass count register write
    input  logic                    cfg_we,
    input  logic [astp_pkg::PASS_W-1:0] cfg_wdata,
    // pixel input: [31:0] red_sum, [63:32] green_sum, [95:64] blue_sum
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [astp_pkg::CHANNELS*astp_pkg::SUM_W-1:0] s_tdata,
    // pixel output: [7:0] red_byte, [15:8] green_byte, [23:16] blue_byte
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [astp_pkg::CHANNELS*astp_pkg::BYTE_W-1:0] m_tdata
);
    import astp_pkg::*;

    localparam int OUT_W = CHANNELS * BYTE_W;

    // divisor held ready for use, zero already mapped to one
    logic [PASS_W-1:0] pass_n_reg;

    // one valid bit per pipeline stage, moves with the data
    logic [PIPE_DEPTH-1:0] valid_reg;

    // output register and skid entry
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] skid_data_reg;

    logic             pipe_en;
    logic             out_free;
    logic [OUT_W-1:0] pipe_bytes;

    // pipeline advances while the skid entry is empty
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_n_reg <= PASS_W'(1);
        end else if (cfg_we) begin
            pass_n_reg <= (cfg_wdata == '0) ? PASS_W'(1) : cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (pipe_en) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // the three color channels run in lockstep
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        astp_channel u_chan (
            .aclk     (aclk),
            .en       (pipe_en),
            .pass_n   (pass_n_reg),
            .sum_in   (s_tdata[c*SUM_W +: SUM_W]),
            .byte_out (pipe_bytes[c*BYTE_W +: BYTE_W])
        );
    end

    // control of output register and skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // pipeline is stalled, drain the skid entry once the output frees
            if (out_free) begin
                m_tvalid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (valid_reg[PIPE_DEPTH-1]) begin
            if (out_free) begin
                m_tvalid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_free) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload of output register and skid entry
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                m_tdata_reg <= skid_data_reg;
            end
        end else if (valid_reg[PIPE_DEPTH-1]) begin
            if (out_free) begin
                m_tdata_reg <= pipe_bytes;
            end else begin
                skid_data_reg <= pipe_bytes;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // skid entry is only used behind a full output register
    `ASTP_ASSERT(a_skid_behind_out, aclk, aresetn, skid_valid_reg |-> m_tvalid_reg, "skid holds data while output is empty")
    // skid fills only when the output transfer was stalled
    `ASTP_ASSERT(a_skid_fill_stall, aclk, aresetn, $rose(skid_valid_reg) |-> $past(m_tvalid_reg && !m_tready), "skid filled without output stall")
    // a finished pixel leaving the pipeline always lands in the output buffer
    `ASTP_ASSERT_NEXT(a_last_stage_kept, aclk, aresetn, valid_reg[PIPE_DEPTH-1] && !skid_valid_reg, m_tvalid_reg, "finished pixel dropped")
    // divisor can never be zero
    `ASTP_ASSERT(a_pass_nonzero, aclk, aresetn, pass_n_reg != '0, "pass count register holds zero")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the sRGB tone-map pixel block
`timescale 1ns / 1ps

module tb_top;

    import astp_pkg::*;

    localparam int IN_W  = CHANNELS * SUM_W;
    localparam int OUT_W = CHANNELS * BYTE_W;

    // curve constants, taken from the sRGB definition rather than from the design
    localparam logic [63:0] LINEAR_EDGE_Q32 = 64'd13446683;   // 0.0031308 in Q0.32
    localparam logic [63:0] LINEAR_GAIN     = 64'd330752;     // 12.92 * 256 * 100
    localparam logic [63:0] LINEAR_DIV      = 64'd100 << 32;
    localparam logic [63:0] CURVE_GAIN      = 64'd27008;      // 1.055 * 256 * 100
    localparam logic [63:0] CURVE_KNEE      = 64'd1408 << 24; // 0.055 * 256 * 100 in Q24
    localparam logic [63:0] CURVE_DIV       = 64'd100 << 24;
    localparam logic [7:0]  CODE_MAX        = 8'd255;

    localparam int RESULT_LATENCY = 23;

    // mantissa with bit 31 set, value = m * 2^e
    typedef struct packed {
        int          e;
        logic [31:0] m;
    } mant_exp_t;

    class srgb_pixel_scoreboard;
        logic [PASS_W-1:0] pass_count;
        logic [OUT_W-1:0]  expected_pixels[$];
        int                failures;
        string             channel_name[CHANNELS];

        function new();
            pass_count      = 1;
            failures        = 0;
            channel_name[0] = "red_byte";
            channel_name[1] = "green_byte";
            channel_name[2] = "blue_byte";
        endfunction

        function mant_exp_t normalize(logic [31:0] x, int e);
            mant_exp_t r;
            r.m = x;
            r.e = e;
            while (!r.m[31]) begin
                r.m = r.m << 1;
                r.e = r.e - 1;
            end
            return r;
        endfunction

        // product truncated back to 32 mantissa bits
        function mant_exp_t mant_mul(mant_exp_t a, mant_exp_t b);
            logic [63:0] prod;
            mant_exp_t   r;
            prod = {32'b0, a.m} * {32'b0, b.m};
            if (prod[63]) begin
                r.m = prod[63:32];
                r.e = a.e + b.e + 32;
            end else begin
                r.m = prod[62:31];
                r.e = a.e + b.e + 31;
            end
            return r;
        endfunction

        function bit mant_le(mant_exp_t a, mant_exp_t b);
            return (a.e < b.e) || ((a.e == b.e) && (a.m <= b.m));
        endfunction

        function logic [7:0] encode_byte(logic [SUM_W-1:0] sum, logic [PASS_W-1:0] count);
            logic [63:0] divisor;
            logic [63:0] uq;
            logic [63:0] num;
            logic [63:0] code;
            logic [31:0] root;
            logic [31:0] cand;
            mant_exp_t   u1, u2, u4, u5;
            mant_exp_t   c1, c2, c4, c8, c12;
            if (sum[SUM_W-1] || sum == '0)
                return 8'd0;
            divisor = (count == '0) ? 64'd1 : {48'b0, count};
            uq = {16'b0, sum, 16'b0} / divisor;
            if (uq[63:32] != '0)
                return CODE_MAX;
            if (uq <= LINEAR_EDGE_Q32)
                return 8'((uq * LINEAR_GAIN) / LINEAR_DIV);
            u1 = normalize(uq[31:0], -32);
            u2 = mant_mul(u1, u1);
            u4 = mant_mul(u2, u2);
            u5 = mant_mul(u4, u1);
            // largest Q0.24 root with root^12 <= u^5
            root = '0;
            for (int bitpos = 23; bitpos >= 0; bitpos--) begin
                cand = root | (32'd1 << bitpos);
                c1   = normalize(cand, -24);
                c2   = mant_mul(c1, c1);
                c4   = mant_mul(c2, c2);
                c8   = mant_mul(c4, c4);
                c12  = mant_mul(c8, c4);
                if (mant_le(c12, u5))
                    root = cand;
            end
            num = CURVE_GAIN * {32'b0, root};
            if (num <= CURVE_KNEE)
                return 8'd0;
            code = (num - CURVE_KNEE) / CURVE_DIV;
            return (code > 64'(CODE_MAX)) ? CODE_MAX : code[7:0];
        endfunction

        function void note_pixel(logic [IN_W-1:0] sums);
            logic [OUT_W-1:0] bytes;
            for (int ch = 0; ch < CHANNELS; ch++)
                bytes[ch*BYTE_W +: BYTE_W] = encode_byte(sums[ch*SUM_W +: SUM_W], pass_count);
            expected_pixels.push_back(bytes);
        endfunction

        function void check_pixel(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (expected_pixels.size() == 0) begin
                $error("pixel transfer out with none pending: m_tdata %h", got);
                failures++;
                return;
            end
            want = expected_pixels.pop_front();
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (got[ch*BYTE_W +: BYTE_W] !== want[ch*BYTE_W +: BYTE_W]) begin
                    $error("%s: expected %0d, actual %0d", channel_name[ch],
                           want[ch*BYTE_W +: BYTE_W], got[ch*BYTE_W +: BYTE_W]);
                    failures++;
                end
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [PASS_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;    // [31:0] red_sum, [63:32] green_sum, [95:64] blue_sum
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;    // [7:0] red_byte, [15:8] green_byte, [23:16] blue_byte

    srgb_pixel_scoreboard sb;
    bit                   calm;    // no idling on either side while set

    average_srgb_tonemap_pixel_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_W-1:0] pixel(logic [SUM_W-1:0] red, logic [SUM_W-1:0] green,
                                              logic [SUM_W-1:0] blue);
        return {blue, green, red};
    endfunction

    // sum spread on a log scale below saturation, with noise, negatives and edges
    function automatic logic [SUM_W-1:0] random_sum(logic [PASS_W-1:0] count);
        logic [63:0] sat;
        logic [63:0] v;
        int          r;
        sat = (count == '0) ? 64'd65536 : ({48'b0, count} << 16);
        if (sat > 64'h7FFF_FFFF)
            sat = 64'h7FFF_FFFF;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom;
        if (r < 12)
            return $urandom | 32'h8000_0000;
        if (r < 15)
            return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'd1;
        if (r < 22) begin
            v = sat + $urandom_range(0, 3);
            return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
        end
        v = {32'b0, $urandom} >> $urandom_range(0, 31);
        v = v % sat + 1;
        return v[31:0];
    endfunction

    task automatic send_pixel(logic [IN_W-1:0] sums);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sums;
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_pixel(sums);
    endtask

    // register write only once every pending pixel has come out
    task automatic write_pass_count(logic [PASS_W-1:0] value);
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.expected_pixels.size() != 0);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we        <= 1'b0;
        sb.pass_count = value;
    endtask

    task automatic run_phase(logic [PASS_W-1:0] count, int items, bit quiet);
        write_pass_count(count);
        calm = quiet;
        repeat (items)
            send_pixel(pixel(random_sum(count), random_sum(count), random_sum(count)));
    endtask

    // result side: random stalls, aligned to the clock edge
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // every result transfer is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_pixel(m_tdata);
    end

    initial begin
        logic [PASS_W-1:0] counts[11];
        sb        = new();
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        calm      = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unit pass count: zero, negatives, extremes, linear-segment edge, saturation edge
        write_pass_count(16'd1);
        send_pixel(pixel(32'd0, 32'd1, 32'hFFFF_FFFF));
        send_pixel(pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001));
        send_pixel(pixel(32'd205, 32'd206, 32'd65535));
        send_pixel(pixel(32'd65536, 32'd65537, 32'd32768));
        send_pixel(pixel(32'd100, 32'd1000, 32'd10000));
        send_pixel(pixel(32'd20000, 32'd40000, 32'd50000));
        send_pixel(pixel(32'd3, 32'd7, 32'd13));
        send_pixel(pixel(32'd207, 32'd512, 32'd65534));

        // pass count zero divides by one
        write_pass_count(16'd0);
        send_pixel(pixel(32'd65535, 32'd65536, 32'd205));
        send_pixel(pixel(32'd206, 32'hFFFF_FFFF, 32'd1));

        // largest pass count: no sum can saturate
        write_pass_count(16'hFFFF);
        send_pixel(pixel(32'h7FFF_FFFF, 32'h8000_0000, 32'd1));
        send_pixel(pixel(32'h4000_0000, 32'h0010_0000, 32'h0200_0000));
        send_pixel(pixel(32'd13434880, 32'd13500416, 32'h7FFE_0000));

        counts = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'd255, 16'd256,
                   16'd4096, 16'hFFFE, 16'($urandom_range(4, 64)), 16'($urandom)};
        foreach (counts[i])
            run_phase(counts[i], 103, (i % 4) == 3);

        s_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (RESULT_LATENCY + 8) @(posedge aclk);

        if (sb.failures == 0 && sb.expected_pixels.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #7_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/astp_pkg.sv
design/astp_channel.sv
design/average_srgb_tonemap_pixel_top.sv
tb/tb_top.sv
